// ===== rtl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg
// shared constants for the vector normalise pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

    // default width of one signed input component
    localparam int COMPONENT_WIDTH_DEF = 16;
    // default number of fraction bits of the normalised outputs
    localparam int FRACTION_BITS_DEF = 14;
    // fraction bits carried by the magnitude (radicand is shifted by twice this)
    localparam int MAG_FRAC_BITS = 8;
    // number of vector lanes
    localparam int LANES = 3;

endpackage

`default_nettype wire

// ===== rtl/vn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt_cell
// one digit step of the square root chain, one root bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module vn_sqrt_cell #(
    parameter int RW     = 48,
    parameter int RTW    = 24,
    parameter int SIDE_W = 53,
    parameter int IDX    = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [RW-1:0]     rad_in,
    input  wire logic [RTW+1:0]    rem_in,
    input  wire logic [RTW-1:0]    root_in,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [RW-1:0]          rad_out,
    output logic [RTW+1:0]         rem_out,
    output logic [RTW-1:0]         root_out,
    output logic [SIDE_W-1:0]      side_out
);

    logic                valid_reg;
    logic [RW-1:0]       rad_reg;
    logic [RTW+1:0]      rem_reg;
    logic [RTW-1:0]      root_reg;
    logic [SIDE_W-1:0]   side_reg;
    logic [RTW+1:0]      rem_next;
    logic [RTW-1:0]      root_next;
    logic [RTW+1:0]      shifted;
    logic [RTW+1:0]      trial;
    logic [1:0]          pair;

    assign in_ready = !valid_reg || out_ready;

    // trial divisor is four times the root so far plus one
    always_comb
    begin
        pair    = rad_in[RW-1-2*IDX -: 2];
        shifted = {rem_in[RTW-1:0], pair};
        trial   = {root_in, 2'b01};
        if (shifted >= trial)
        begin
            rem_next  = shifted - trial;
            root_next = {root_in[RTW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = shifted;
            root_next = {root_in[RTW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rad_reg  <= rad_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

// ===== rtl/vn_div_cell.sv =====
// ----------------------------------------------------------------------------
// vn_div_cell
// one restoring division step for all three lanes against a shared divisor
// ----------------------------------------------------------------------------
`default_nettype none

module vn_div_cell #(
    parameter int RTW    = 24,
    parameter int QW     = 15,
    parameter int SIDE_W = 5
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [RTW-1:0]                     div_in,
    input  wire logic [vn_pkg::LANES-1:0][RTW-1:0]  rem_in,
    input  wire logic [vn_pkg::LANES-1:0][QW-1:0]   quo_in,
    input  wire logic [SIDE_W-1:0]                  side_in,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [RTW-1:0]                          div_out,
    output logic [vn_pkg::LANES-1:0][RTW-1:0]       rem_out,
    output logic [vn_pkg::LANES-1:0][QW-1:0]        quo_out,
    output logic [SIDE_W-1:0]                       side_out
);

    logic                                 valid_reg;
    logic [RTW-1:0]                       div_reg;
    logic [vn_pkg::LANES-1:0][RTW-1:0]    rem_reg;
    logic [vn_pkg::LANES-1:0][QW-1:0]     quo_reg;
    logic [SIDE_W-1:0]                    side_reg;
    logic [vn_pkg::LANES-1:0][RTW-1:0]    rem_next;
    logic [vn_pkg::LANES-1:0][QW-1:0]     quo_next;
    logic [RTW:0]                         trial;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < vn_pkg::LANES; i++)
        begin
            trial = {rem_in[i], 1'b0};
            if (trial >= {1'b0, div_in})
            begin
                rem_next[i] = RTW'(trial - {1'b0, div_in});
                quo_next[i] = {quo_in[i][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[RTW-1:0];
                quo_next[i] = {quo_in[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            div_reg  <= div_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign div_out   = div_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

// ===== rtl/vector_normalize_top.sv =====
// ----------------------------------------------------------------------------
// vector_normalize_top
// unit vector of a two- or three-component signed vector in signed fixed point
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle while m_tready is high, set by the chain of root and divide cells
// every cell holds one item, so bubbles collapse and a stalled output blocks
// only the cells behind a full one
// reset: rst_n clears all valid flags at once, payload registers are not reset
`default_nettype none

module vector_normalize_top #(
    parameter int COMPONENT_WIDTH = vn_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = vn_pkg::FRACTION_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // input channel
    input  wire logic s_tvalid,
    output logic      s_tready,
    // x_in, y_in, z_in from bit 0 up, zero padded to bytes
    input  wire logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    // mode
    input  wire logic [0:0] s_tuser,
    // result channel
    output logic      m_tvalid,
    input  wire logic m_tready,
    // x_out, y_out, z_out from bit 0 up, zero padded to bytes
    output logic [((3*(FRACTION_BITS+2)+7)/8)*8-1:0] m_tdata,
    // zero_length
    output logic [0:0] m_tuser
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int SW     = 2*CW;                         // sum of squares
    localparam int RW     = SW + 2*vn_pkg::MAG_FRAC_BITS; // radicand
    localparam int RTW    = CW + vn_pkg::MAG_FRAC_BITS;   // magnitude
    localparam int QW     = FRACTION_BITS + 1;            // quotient
    localparam int OW     = FRACTION_BITS + 2;            // output field
    localparam int ODW    = ((3*OW+7)/8)*8;
    localparam int SSIDE  = 3*CW + 5;
    localparam int DSIDE  = 5;
    localparam int PRESHIFT = vn_pkg::MAG_FRAC_BITS - 1;

    // ---------------- stage a: magnitudes and squares ----------------
    logic                      a_valid_reg;
    logic [2:0][CW-1:0]        a_abs_reg;
    logic [2:0][SW-1:0]        a_sq_reg;
    logic [2:0]                a_neg_reg;
    logic                      a_three_reg;
    logic [2:0][CW-1:0]        a_abs_next;
    logic [2:0]                a_neg_next;
    logic [2:0][CW-1:0]        comp;
    logic                      a_ready;

    // ---------------- stage b: sum of squares ----------------
    logic                      b_valid_reg;
    logic [RW-1:0]             b_rad_reg;
    logic [SSIDE-1:0]          b_side_reg;
    logic [SW-1:0]             b_sum;
    logic                      b_ready;

    // ---------------- root chain ----------------
    logic [RTW:0]                 sq_valid;
    logic [RTW:0]                 sq_ready;
    logic [RTW:0][RW-1:0]         sq_rad;
    logic [RTW:0][RTW+1:0]        sq_rem;
    logic [RTW:0][RTW-1:0]        sq_root;
    logic [RTW:0][SSIDE-1:0]      sq_side;

    // ---------------- divide chain ----------------
    logic [QW:0]                                  dv_valid;
    logic [QW:0]                                  dv_ready;
    logic [QW:0][RTW-1:0]                         dv_div;
    logic [QW:0][vn_pkg::LANES-1:0][RTW-1:0]      dv_rem;
    logic [QW:0][vn_pkg::LANES-1:0][QW-1:0]       dv_quo;
    logic [QW:0][DSIDE-1:0]                       dv_side;

    // ---------------- output register ----------------
    logic                      o_valid_reg;
    logic [2:0][OW-1:0]        o_val_reg;
    logic                      o_zero_reg;
    logic [2:0][OW-1:0]        o_val_next;
    logic [QW-1:0]             q_clamped;
    logic [2:0]                last_neg;
    logic                      last_three;
    logic                      last_zero;
    logic                      o_ready;

    // split the input transfer and take absolute values
    always_comb
    begin
        comp[0] = s_tdata[CW-1:0];
        comp[1] = s_tdata[2*CW-1:CW];
        comp[2] = s_tuser[0] ? s_tdata[3*CW-1:2*CW] : '0;
        for (int i = 0; i < 3; i++)
        begin
            a_neg_next[i] = comp[i][CW-1];
            a_abs_next[i] = comp[i][CW-1] ? CW'(~comp[i] + 1'b1) : comp[i];
        end
    end

    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    // one multiplier per lane, registered
    always_ff @(posedge clk)
    begin
        if (a_ready && s_tvalid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_sq_reg[i] <= SW'(a_abs_next[i] * a_abs_next[i]);
            end
            a_abs_reg   <= a_abs_next;
            a_neg_reg   <= a_neg_next;
            a_three_reg <= s_tuser[0];
        end
    end

    // sum of squares never exceeds 3 * 2^(2*CW-2), so it fits SW bits
    assign b_sum   = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
    assign b_ready = !b_valid_reg || sq_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // side word: abs x/y/z, neg x/y/z, three, zero flag (from bit 0 up)
    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_rad_reg  <= {b_sum, {(2*vn_pkg::MAG_FRAC_BITS){1'b0}}};
            b_side_reg <= {(b_sum == '0), a_three_reg, a_neg_reg, a_abs_reg};
        end
    end

    // root chain, one magnitude bit per cell
    assign sq_valid[0] = b_valid_reg;
    assign sq_rad[0]   = b_rad_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = b_side_reg;

    for (genvar k = 0; k < RTW; k++)
    begin : g_sqrt
        vn_sqrt_cell #(
            .RW     (RW),
            .RTW    (RTW),
            .SIDE_W (SSIDE),
            .IDX    (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[k]),
            .in_ready  (sq_ready[k]),
            .rad_in    (sq_rad[k]),
            .rem_in    (sq_rem[k]),
            .root_in   (sq_root[k]),
            .side_in   (sq_side[k]),
            .out_valid (sq_valid[k+1]),
            .out_ready (sq_ready[k+1]),
            .rad_out   (sq_rad[k+1]),
            .rem_out   (sq_rem[k+1]),
            .root_out  (sq_root[k+1]),
            .side_out  (sq_side[k+1])
        );
    end

    // quotient is at most 2^FRACTION_BITS, so the partial remainder starts at
    // abs << (MAG_FRAC_BITS - 1), which is below the magnitude
    assign sq_ready[RTW] = dv_ready[0];
    assign dv_valid[0]   = sq_valid[RTW];
    assign dv_div[0]     = sq_root[RTW];
    assign dv_side[0]    = sq_side[RTW][SSIDE-1:3*CW];
    always_comb
    begin
        for (int i = 0; i < vn_pkg::LANES; i++)
        begin
            dv_rem[0][i] = RTW'(sq_side[RTW][i*CW +: CW]) << PRESHIFT;
            dv_quo[0][i] = '0;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        vn_div_cell #(
            .RTW    (RTW),
            .QW     (QW),
            .SIDE_W (DSIDE)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[k]),
            .in_ready  (dv_ready[k]),
            .div_in    (dv_div[k]),
            .rem_in    (dv_rem[k]),
            .quo_in    (dv_quo[k]),
            .side_in   (dv_side[k]),
            .out_valid (dv_valid[k+1]),
            .out_ready (dv_ready[k+1]),
            .div_out   (dv_div[k+1]),
            .rem_out   (dv_rem[k+1]),
            .quo_out   (dv_quo[k+1]),
            .side_out  (dv_side[k+1])
        );
    end

    // clamp, apply sign, force zero vector and unused z lane to zero
    assign dv_ready[QW] = o_ready;
    assign o_ready      = !o_valid_reg || m_tready;
    assign last_neg     = dv_side[QW][2:0];
    assign last_three   = dv_side[QW][3];
    assign last_zero    = dv_side[QW][4];

    always_comb
    begin
        q_clamped = '0;
        for (int i = 0; i < 3; i++)
        begin
            q_clamped = (dv_quo[QW][i] > (QW'(1) << FRACTION_BITS)) ?
                        (QW'(1) << FRACTION_BITS) : dv_quo[QW][i];
            o_val_next[i] = last_neg[i] ? OW'(~{1'b0, q_clamped} + 1'b1)
                                        : {1'b0, q_clamped};
            if (last_zero || (i == 2 && !last_three))
            begin
                o_val_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= dv_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && dv_valid[QW])
        begin
            o_val_reg  <= o_val_next;
            o_zero_reg <= last_zero;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = ODW'(o_val_reg);
    assign m_tuser  = o_zero_reg;

endmodule

`default_nettype wire

// ===== rtl/vn_checker.sv =====
// ----------------------------------------------------------------------------
// vn_checker
// port level checks of the vector normalise block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module vn_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // a zero length vector gives all zero components
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero length result with non-zero data");

    // x and y components stay within plus or minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384 &&
                      $signed(m_tdata[15:0]) >= -16'sd16384 &&
                      $signed(m_tdata[31:16]) <= 16'sd16384 &&
                      $signed(m_tdata[31:16]) >= -16'sd16384))
        else $error("normalised component out of range");

    // nothing comes out right after reset, the pipeline is longer than that
    assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result valid straight after reset");

    // the input is free while the result side is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

endmodule

bind vector_normalize_top vn_checker u_vn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== sim/vector_normalize_top_tb.sv =====
// ----------------------------------------------------------------------------
// vector_normalize_top_tb
// self-checking bench for the vector normalise pipeline: directed corner
// vectors then random vectors, random gaps on both channels, a long output
// stall and a full drain, every result checked against an own predictor
// ----------------------------------------------------------------------------
`default_nettype none

module vector_normalize_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = vn_pkg::COMPONENT_WIDTH_DEF;
    localparam int FB         = vn_pkg::FRACTION_BITS_DEF;
    localparam int OW         = FB + 2;
    localparam int IN_BYTES   = (3 * CW + 7) / 8;
    localparam int OUT_BYTES  = (3 * OW + 7) / 8;
    localparam int LATENCY    = 3 + (CW + 8) + (FB + 1);
    localparam int RAND_ITEMS = 950;
    localparam int STALL_LIMIT = 5000;

    // operating mode carried on s_tuser
    typedef enum logic { MODE_2D = 1'b0, MODE_3D = 1'b1 } vec_mode_e;

    typedef struct packed {
        logic [OW-1:0] x;
        logic [OW-1:0] y;
        logic [OW-1:0] z;
        logic          zero_len;
    } unit_vec_t;

    // ------------------------------------------------------------------
    // predictor and store of expected unit vectors
    // ------------------------------------------------------------------
    class unit_vec_scoreboard;
        unit_vec_t pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // floor(sqrt(s * 2^16)), bit by bit
        static function longint unsigned magnitude(longint unsigned s);
            logic [79:0]    rad;
            logic [79:0]    rem;
            logic [79:0]    trial;
            longint unsigned root;
            rad  = {s, 16'd0};
            rem  = '0;
            root = 0;
            for (int i = 39; i >= 0; i--) begin
                rem   = (rem << 2) | rad[2*i +: 2];
                trial = {root, 2'b01};
                root  = root << 1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = root | 1;
                end
            end
            return root;
        endfunction

        // signed component scaled by 2^(FB+8)/m, truncated towards zero
        static function logic [OW-1:0] scale(logic signed [CW-1:0] c,
                                             longint unsigned m);
            longint unsigned a;
            logic [127:0]    q;
            a = (c < 0) ? longint'(-longint'(c)) : longint'(c);
            q = ({64'd0, a} << (FB + 8)) / m;
            if (q > (128'd1 << FB))
                q = 128'd1 << FB;
            return (c < 0) ? OW'(-q) : OW'(q);
        endfunction

        function void note_input(vec_mode_e mode, logic signed [CW-1:0] x,
                                 logic signed [CW-1:0] y, logic signed [CW-1:0] z);
            longint    s;
            longint unsigned m;
            unit_vec_t r;
            s = longint'(x) * x + longint'(y) * y;
            if (mode == MODE_3D)
                s += longint'(z) * z;
            if (s == 0) begin
                r = '{x: '0, y: '0, z: '0, zero_len: 1'b1};
            end
            else begin
                m = magnitude(s);
                r.x = scale(x, m);
                r.y = scale(y, m);
                r.z = (mode == MODE_3D) ? scale(z, m) : '0;
                r.zero_len = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(unit_vec_t got);
            unit_vec_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d zl=%0b", $time,
                         $signed(got.x), $signed(got.y), $signed(got.z), got.zero_len);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: x_out expected %0d actual %0d", $time,
                         $signed(want.x), $signed(got.x));
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: y_out expected %0d actual %0d", $time,
                         $signed(want.y), $signed(got.y));
                errors++;
            end
            if (got.z !== want.z) begin
                $display("%0t: z_out expected %0d actual %0d", $time,
                         $signed(want.z), $signed(got.z));
                errors++;
            end
            if (got.zero_len !== want.zero_len) begin
                $display("%0t: zero_length expected %0b actual %0b", $time,
                         want.zero_len, got.zero_len);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // x_in, y_in, z_in from bit 0 up, zero padded to bytes
    logic [IN_BYTES*8-1:0]    s_tdata = '0;
    // mode
    logic [0:0]               s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // x_out, y_out, z_out from bit 0 up, zero padded to bytes
    logic [OUT_BYTES*8-1:0]   m_tdata;
    // zero_length
    logic [0:0]               m_tuser;

    unit_vec_scoreboard sb = new();
    bit  long_hold = 1'b0;    // asks the receiver for one long stall
    bit  sending_done = 1'b0;
    int  idle_cycles = 0;

    always #10 clk = ~clk;

    vector_normalize_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // offer one vector after a random gap unless no_gap is set, hold it until the transfer happens
    task automatic send_vector(vec_mode_e mode, logic [CW-1:0] x,
                               logic [CW-1:0] y, logic [CW-1:0] z, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_BYTES*8 - 3*CW){1'b0}}, z, y, x};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(mode, x, y, z);
    endtask

    function automatic logic [CW-1:0] rand_component();
        // mix of full range, extremes and small magnitudes
        case ($urandom_range(0, 5))
            0:       return CW'($urandom_range(0, 3)) - CW'(1);
            1:       return $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}}
                                                 : {1'b0, {(CW-1){1'b1}}};
            2:       return CW'($signed(CW'($urandom_range(0, 64))) - 32);
            default: return CW'($urandom);
        endcase
    endfunction

    // receiver: results checked on each transfer, random stalls, plus one long hold when asked
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result('{x: m_tdata[0 +: OW], y: m_tdata[OW +: OW],
                              z: m_tdata[2*OW +: OW], zero_len: m_tuser[0]});
    end

    initial begin : receiver
        int hold;
        @(posedge rst_n);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CW-1:0] max_pos;
        logic [CW-1:0] max_neg;
        max_pos = {1'b0, {(CW-1){1'b1}}};
        max_neg = {1'b1, {(CW-1){1'b0}}};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: zero vectors, axes, extremes, ignored z in 2d mode
        send_vector(MODE_2D, '0, '0, '0, 0);
        send_vector(MODE_3D, '0, '0, '0, 0);
        send_vector(MODE_2D, '0, '0, max_neg, 0);
        send_vector(MODE_3D, 1, 0, 0, 0);
        send_vector(MODE_3D, 0, '1, 0, 0);
        send_vector(MODE_3D, 0, 0, max_neg, 0);
        send_vector(MODE_3D, max_neg, max_neg, max_neg, 0);
        send_vector(MODE_3D, max_pos, max_pos, max_pos, 0);
        send_vector(MODE_3D, max_pos, max_neg, max_pos, 0);
        send_vector(MODE_2D, max_neg, max_neg, max_pos, 0);
        send_vector(MODE_2D, max_pos, 1, '1, 0);
        send_vector(MODE_2D, 3, 4, 5, 0);
        send_vector(MODE_3D, '1, '1, '1, 0);
        send_vector(MODE_3D, 1, max_pos, '1, 0);
        send_vector(MODE_3D, max_neg, 0, 0, 0);
        send_vector(MODE_2D, 16'h5555, 16'haaaa, 16'h0f0f, 0);

        // back to back with the output held off, so the pipe fills and stalls
        long_hold = 1'b1;
        for (int i = 0; i < 80; i++)
            send_vector(vec_mode_e'($urandom_range(0, 1)), rand_component(),
                        rand_component(), rand_component(), 1);

        // pause until the pipe has drained completely
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);

        for (int i = 0; i < RAND_ITEMS; i++)
            send_vector(vec_mode_e'($urandom_range(0, 1)), rand_component(),
                        rand_component(), rand_component(), ($urandom_range(0, 9) < 3));
        s_tvalid <= 1'b0;
        sending_done = 1'b1;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/vn_pkg.sv
rtl/vn_sqrt_cell.sv
rtl/vn_div_cell.sv
rtl/vector_normalize_top.sv
rtl/vn_checker.sv
sim/vector_normalize_top_tb.sv
